// ===== rtl/dmarf_pkg.sv =====
// dmarf_pkg: shared types, register map codes and masks for the dma register file
// used by dmarf_ctrl, dmarf_datapath and dma_register_file_irq_priority_core
// no dependencies
package dmarf_pkg;

  localparam int NUM_CHANNELS = 7;
  localparam int CH_W         = 3;

  // function codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_DONE  = 2'd2;

  // access width codes
  localparam logic [1:0] AW_BYTE = 2'd0;
  localparam logic [1:0] AW_HALF = 2'd1;
  localparam logic [1:0] AW_WORD = 2'd2;

  // register select within a channel or the control area
  localparam logic [1:0] REG_ADDR  = 2'd0;
  localparam logic [1:0] REG_COUNT = 2'd1;
  localparam logic [1:0] REG_CTRL  = 2'd2;
  localparam logic [1:0] REG_ALIAS = 2'd3;

  localparam logic [1:0] REG_PRIO  = 2'd0;
  localparam logic [1:0] REG_INT   = 2'd1;
  localparam logic [1:0] REG_FIX0  = 2'd2;
  localparam logic [1:0] REG_FIX1  = 2'd3;

  localparam logic [CH_W-1:0] CH_CONTROL = 3'd7;
  localparam logic [6:0]      OFF_INT_BYTE = 7'h76;
  localparam logic [6:0]      OFF_INT_WORD = 7'h74;

  // masks
  localparam logic [31:0] INT_WR_SET_MASK   = 32'h00ff803f;
  localparam logic [31:0] INT_WR_CLR_MASK   = 32'h7f000000;
  localparam logic [31:0] INT_IRQ_BIT       = 32'h80000000;
  localparam logic [31:0] CTRL_RD_CLR_MASK  = 32'h8e88f8fc;
  localparam logic [31:0] CTRL6_RD_CLR_MASK = 32'haeffffff;
  localparam logic [31:0] ADDR_RD_CLR_MASK  = 32'hff000000;
  localparam logic [31:0] INT_RD_CLR_MASK   = 32'h00007fc0;
  localparam logic [31:0] FIXED_VAL0        = 32'h6ffac611;
  localparam logic [31:0] FIXED_VAL1        = 32'h00ffffff;
  localparam logic [31:0] CTRL_ACTIVE_MASK  = 32'h11000000;
  localparam logic [31:0] CTRL6_RD_SET      = 32'h00000002;
  localparam logic [31:0] INT_KEEP_MASK     = 32'hff000000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EVAL,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic load;  // capture the input transfer
    logic exec;  // apply read, write or completion
    logic eval;  // recompute irq and serve channel into output regs
  } dp_cmd_t;

endpackage

// ===== rtl/dmarf_ctrl.sv =====
// dmarf_ctrl: sequencing state machine for the dma register file
// depends on dmarf_pkg
module dmarf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  output logic              in_ready,
  output logic              out_valid,
  output dmarf_pkg::dp_cmd_t cmd
);
  import dmarf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: state_nxt = ST_EVAL;
      ST_EVAL: state_nxt = ST_HOLD;
      ST_HOLD: begin
        if (out_ready) state_nxt = in_valid ? ST_EXEC : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_EXEC: cmd.exec = 1'b1;
      ST_EVAL: cmd.eval = 1'b1;
      ST_HOLD: begin
        out_valid = 1'b1;
        // next transfer may enter while the result leaves
        in_ready  = out_ready;
      end
      default: ;
    endcase
    cmd.load = in_valid & in_ready;
  end

endmodule

// ===== rtl/dmarf_datapath.sv =====
// dmarf_datapath: channel and control registers, read mux, irq and priority logic
// depends on dmarf_pkg
module dmarf_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dmarf_pkg::dp_cmd_t          cmd,
  input  logic [1:0]                  in_func,
  input  logic [6:0]                  in_byte_offset,
  input  logic [1:0]                  in_access_width,
  input  logic [31:0]                 in_write_data,
  input  logic [dmarf_pkg::CH_W-1:0]  in_done_channel,
  output logic [31:0]                 out_read_data,
  output logic                        out_irq_line,
  output logic                        out_serve_valid,
  output logic [dmarf_pkg::CH_W-1:0]  out_serve_channel
);
  import dmarf_pkg::*;

  // captured transfer
  logic [1:0]      func_r;
  logic [6:0]      off_r;
  logic [1:0]      aw_r;
  logic [31:0]     data_r;
  logic [CH_W-1:0] done_r;

  // architectural state
  logic [31:0] priority_r;
  logic [31:0] interrupt_r;
  logic [23:0] chan_address_r [NUM_CHANNELS];
  logic [31:0] chan_count_r   [NUM_CHANNELS];
  logic [31:0] chan_control_r [NUM_CHANNELS];

  logic [CH_W-1:0] rd_ch;
  logic [1:0]      rd_rg;
  logic            rd_present;
  logic [31:0]     word_rd;
  logic [31:0]     rdata;

  logic            wr_en;
  logic [6:0]      wr_off;
  logic [31:0]     wr_data;
  logic [CH_W-1:0] wr_ch;
  logic [1:0]      wr_rg;
  logic            wr_present;
  logic            done_present;

  logic            irq;
  logic            found;
  logic [2:0]      best_pri;
  logic [CH_W-1:0] best_ch;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      off_r  <= in_byte_offset;
      aw_r   <= in_access_width;
      data_r <= in_write_data;
      done_r <= in_done_channel;
    end
  end

  // read path
  assign rd_ch      = off_r[6:4];
  assign rd_rg      = off_r[3:2];
  assign rd_present = (rd_ch != CH_CONTROL) && (int'(rd_ch) < NUM_CHANNELS);

  always_comb begin
    word_rd = '0;
    if (rd_ch == CH_CONTROL) begin
      case (rd_rg)
        REG_PRIO: word_rd = priority_r;
        REG_INT:  word_rd = interrupt_r & ~INT_RD_CLR_MASK;
        REG_FIX0: word_rd = FIXED_VAL0;
        REG_FIX1: word_rd = FIXED_VAL1;
        default:  word_rd = '0;
      endcase
    end else if (rd_present) begin
      case (rd_rg)
        REG_ADDR:  word_rd = {8'h00, chan_address_r[rd_ch]} & ~ADDR_RD_CLR_MASK;
        REG_COUNT: word_rd = chan_count_r[rd_ch];
        default: begin
          if (rd_ch == CH_W'(6)) begin
            word_rd = (chan_control_r[rd_ch] & ~CTRL6_RD_CLR_MASK) | CTRL6_RD_SET;
          end else begin
            word_rd = chan_control_r[rd_ch] & ~CTRL_RD_CLR_MASK;
          end
        end
      endcase
    end
  end

  always_comb begin
    rdata = '0;
    if (func_r == FUNC_READ) begin
      case (aw_r)
        AW_BYTE: rdata = {24'h0, 8'(word_rd >> {off_r[1:0], 3'b000})};
        AW_HALF: rdata = {16'h0, 16'(word_rd >> {off_r[1], 4'b0000})};
        default: rdata = word_rd;
      endcase
    end
  end

  // write path; a byte write to the interrupt flag byte becomes a shifted word write
  always_comb begin
    wr_en   = 1'b0;
    wr_off  = off_r;
    wr_data = data_r;
    if (func_r == FUNC_WRITE) begin
      if (aw_r == AW_BYTE && off_r == OFF_INT_BYTE) begin
        wr_en   = 1'b1;
        wr_off  = OFF_INT_WORD;
        wr_data = {data_r[15:0], 16'h0000};
      end else if (aw_r == AW_WORD) begin
        wr_en = 1'b1;
      end
    end
  end

  assign wr_ch        = wr_off[6:4];
  assign wr_rg        = wr_off[3:2];
  assign wr_present   = (wr_ch != CH_CONTROL) && (int'(wr_ch) < NUM_CHANNELS);
  assign done_present = (done_r != CH_CONTROL) && (int'(done_r) < NUM_CHANNELS);

  // interrupt line from the updated interrupt register
  assign irq = interrupt_r[15] |
               (interrupt_r[23] & (|(interrupt_r[22:16] & interrupt_r[30:24])));

  // lowest priority code among enabled active channels, ties to higher channel
  always_comb begin
    found    = 1'b0;
    best_pri = '0;
    best_ch  = '0;
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      if (priority_r[4*c+3] && (|(chan_control_r[c] & CTRL_ACTIVE_MASK)) &&
          (!found || priority_r[4*c +: 3] <= best_pri)) begin
        found    = 1'b1;
        best_pri = priority_r[4*c +: 3];
        best_ch  = CH_W'(c);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      priority_r  <= '0;
      interrupt_r <= '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_address_r[i] <= '0;
        chan_count_r[i]   <= '0;
        chan_control_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (wr_en) begin
        if (wr_ch == CH_CONTROL) begin
          case (wr_rg)
            REG_PRIO: priority_r <= wr_data;
            REG_INT: begin
              interrupt_r <= ((interrupt_r & INT_KEEP_MASK) | (wr_data & INT_WR_SET_MASK)) &
                             ~(wr_data & INT_WR_CLR_MASK);
            end
            default: ;
          endcase
        end else if (wr_present) begin
          case (wr_rg)
            REG_ADDR:  chan_address_r[wr_ch] <= wr_data[23:0];
            REG_COUNT: chan_count_r[wr_ch]   <= wr_data;
            REG_CTRL:  chan_control_r[wr_ch] <= wr_data;
            default: ;
          endcase
        end
      end else if (func_r == FUNC_DONE && done_present) begin
        chan_control_r[done_r] <= chan_control_r[done_r] & ~CTRL_ACTIVE_MASK;
        if (interrupt_r[{2'b10, done_r}]) interrupt_r[{2'b11, done_r}] <= 1'b1;
      end
    end else if (cmd.eval) begin
      interrupt_r[31] <= irq;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_read_data <= rdata;
    end
    if (cmd.eval) begin
      out_irq_line      <= irq;
      out_serve_valid   <= found;
      out_serve_channel <= best_ch;
    end
  end

endmodule

// ===== rtl/dma_register_file_irq_priority_core.sv =====
// dma_register_file_irq_priority_core: register side of a seven-channel dma controller
// instantiates dmarf_ctrl and dmarf_datapath; depends on dmarf_pkg
//
// usage:
//   the input channel carries one bus register read, register write or channel
//   completion event per transfer (in_func selects which). every input transfer
//   produces exactly one result transfer: the read data (zero unless a read),
//   the recomputed interrupt line and the highest-priority enabled channel with
//   its start or busy bit set.
//   timing: read data is registered in exec, irq and serve outputs in eval, and
//   the result is valid in hold; only one transfer is in flight at a time;
//   the controller steps capture, register update and irq/priority evaluation,
//   and a new input is taken in the same cycle the previous result is taken.
//   stall: the result holds on the out_ ports until out_ready; in_ready stays
//   low meanwhile, so nothing is lost or reordered.
//   reset: rst_n low clears all channel, priority and interrupt registers and
//   returns the controller to idle with no result pending.
module dma_register_file_irq_priority_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_func,
  input  logic [6:0]                  in_byte_offset,
  input  logic [1:0]                  in_access_width,
  input  logic [31:0]                 in_write_data,
  input  logic [dmarf_pkg::CH_W-1:0]  in_done_channel,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [31:0]                 out_read_data,
  output logic                        out_irq_line,
  output logic                        out_serve_valid,
  output logic [dmarf_pkg::CH_W-1:0]  out_serve_channel
);
  import dmarf_pkg::*;

  dp_cmd_t cmd;

  dmarf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  dmarf_datapath u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_func           (in_func),
    .in_byte_offset    (in_byte_offset),
    .in_access_width   (in_access_width),
    .in_write_data     (in_write_data),
    .in_done_channel   (in_done_channel),
    .out_read_data     (out_read_data),
    .out_irq_line      (out_irq_line),
    .out_serve_valid   (out_serve_valid),
    .out_serve_channel (out_serve_channel)
  );

endmodule
